// ===== sv/trf_pkg.sv =====
// Package for the tangent range finder: state type and fixed constants.
// No dependencies.
package trf_pkg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_QDIV,
        ST_QWAIT,
        ST_TDIV,
        ST_TWAIT,
        ST_DDIV,
        ST_DWAIT,
        ST_MUL,
        ST_DONE
    } t_state;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_RANGE = 2'd1;
    localparam logic [1:0] STATUS_SAT   = 2'd2;

    localparam int OUT_W = 48;
    localparam int ANG_W = 17;
    localparam int HGT_W = 23;
    localparam int CNT_W = 4;
    localparam int CFG_W = 23;

    localparam logic CFG_HEIGHT = 1'b0;
    localparam logic CFG_TERMS  = 1'b1;

endpackage

// ===== sv/trf_divider.sv =====
// Restoring radix-2 divider, one quotient bit per cycle.
// Depends on nothing.
module trf_divider #(
    parameter int W = 64
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_num,
    input  logic [W-1:0] i_den,
    output logic         o_done,
    output logic [W-1:0] o_quo
);
    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  r_quo, n_quo;
    logic [W-1:0]  r_rem, n_rem;
    logic [W-1:0]  r_den;
    logic [CW-1:0] r_cnt;
    logic          r_busy, r_done;
    logic [W:0]    w_trial;
    logic [W:0]    w_shift;

    always_comb begin
        w_shift = {r_rem, r_quo[W-1]};
        w_trial = w_shift - {1'b0, r_den};
        n_quo   = {r_quo[W-2:0], ~w_trial[W]};
        n_rem   = w_trial[W] ? w_shift[W-1:0] : w_trial[W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
endmodule

// ===== sv/trf_mulsat.sv =====
// Multi-cycle (a*b)>>F with saturation to 48 bits, 16-bit digit of b per cycle.
// Depends on trf_pkg.
module trf_mulsat #(
    parameter int FRAC_BITS = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [63:0]               i_a,
    input  logic [trf_pkg::OUT_W-1:0] i_b,
    output logic                      o_done,
    output logic [trf_pkg::OUT_W-1:0] o_res,
    output logic                      o_sat
);
    import trf_pkg::*;

    // Product accumulated MSB digit first: acc = acc*2^16 + a*digit.
    logic [127:0] r_acc;
    logic [OUT_W-1:0] r_b;
    logic [63:0]  r_a;
    logic [1:0]   r_cnt;
    logic         r_busy, r_done;
    logic [79:0]  w_part;
    logic [127:0] w_full;

    assign w_part = r_a * r_b[OUT_W-1 -: 16];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 2'd2;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == 2'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= '0;
            r_b   <= i_b;
            r_a   <= i_a;
        end else if (r_busy) begin
            r_acc <= {r_acc[111:0], 16'd0} + {48'd0, w_part};
            r_b   <= {r_b[OUT_W-17:0], 16'd0};
        end
    end

    assign w_full = r_acc >> FRAC_BITS;
    assign o_sat  = (w_full[127:OUT_W] != '0);
    assign o_res  = o_sat ? {OUT_W{1'b1}} : w_full[OUT_W-1:0];
    assign o_done = r_done;
endmodule

// ===== sv/trf_seq.sv =====
// Sequencer: range checks, continued fraction loop, distance and height steps.
// Depends on trf_pkg, trf_divider, trf_mulsat.
module trf_seq #(
    parameter int FRAC_BITS = 16,
    parameter int MAX_TERMS = 13
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_go,
    input  logic [trf_pkg::ANG_W-1:0] i_alpha,
    input  logic [trf_pkg::ANG_W-1:0] i_beta,
    input  logic [trf_pkg::HGT_W-1:0] i_height,
    input  logic [trf_pkg::CNT_W-1:0] i_terms,
    output logic                      o_busy,
    output logic                      o_valid,
    output logic [trf_pkg::OUT_W-1:0] o_distance,
    output logic [trf_pkg::OUT_W-1:0] o_object_height,
    output logic [1:0]                o_status
);
    import trf_pkg::*;

    localparam logic [63:0] ONE2 = 64'd1 << (2 * FRAC_BITS);
    localparam logic [63:0] ANGLE_LIMIT = (64'd14 << FRAC_BITS) / 64'd10;
    localparam logic [63:0] HEIGHT_LIMIT = 64'd100 << FRAC_BITS;
    localparam logic [63:0] OUT_MAX = {16'd0, {OUT_W{1'b1}}};

    t_state r_state, n_state;
    logic [ANG_W-1:0] r_alpha, r_beta;
    logic [HGT_W-1:0] r_h;
    logic [CNT_W-1:0] r_n;
    logic [CNT_W-1:0] r_i, n_i;
    logic             r_second, n_second;
    logic [63:0]      r_t, n_t, r_ta;
    logic [63:0]      r_q, n_q;
    logic [OUT_W-1:0] r_dist, n_dist, r_objh, n_objh;
    logic             r_sat, n_sat;
    logic [1:0]       r_status, n_status;
    logic [63:0]      n_ta;

    logic        w_dstart, w_ddone;
    logic [63:0] w_num, w_den, w_quo;
    logic        w_mstart, w_mdone, w_msat;
    logic [OUT_W-1:0] w_mres;
    logic [64:0] w_sum;
    logic [ANG_W-1:0] w_x;

    trf_divider #(.W(64)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_dstart),
        .i_num(w_num), .i_den(w_den), .o_done(w_ddone), .o_quo(w_quo)
    );

    // The product takes the tangent as it is being stored, since the multiply
    // starts on the same edge that finishes the last division.
    trf_mulsat #(.FRAC_BITS(FRAC_BITS)) u_mul (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_mstart),
        .i_a(n_t), .i_b(r_dist), .o_done(w_mdone), .o_res(w_mres), .o_sat(w_msat)
    );

    assign w_x   = r_second ? r_beta : r_alpha;
    assign w_sum = {17'd0, w_mres} + {42'd0, r_h};

    always_comb begin
        n_state  = r_state;
        n_i      = r_i;
        n_second = r_second;
        n_t      = r_t;
        n_q      = r_q;
        n_dist   = r_dist;
        n_objh   = r_objh;
        n_sat    = r_sat;
        n_status = r_status;
        w_dstart = 1'b0;
        w_mstart = 1'b0;
        w_num    = '0;
        w_den    = 64'd1;
        n_ta     = r_ta;
        case (r_state)
            ST_IDLE: begin
                if (i_go) n_state = ST_CHECK;
            end
            ST_CHECK: begin
                n_dist = '0; n_objh = '0; n_sat = 1'b0;
                n_t = '0; n_i = r_n; n_second = 1'b0;
                if (r_alpha == '0 || 64'(r_alpha) > ANGLE_LIMIT
                        || 64'(r_beta) > ANGLE_LIMIT || r_h == '0
                        || 64'(r_h) > HEIGHT_LIMIT || r_n == '0
                        || 32'(r_n) > MAX_TERMS) begin
                    n_status = STATUS_RANGE;
                    n_state  = ST_DONE;
                end else begin
                    n_state = ST_QDIV;
                end
            end
            ST_QDIV: begin
                w_dstart = 1'b1;
                w_num = 64'({r_i, 1'b0} - 5'd1) << (2 * FRAC_BITS);
                w_den = 64'(w_x);
                n_state = ST_QWAIT;
            end
            ST_QWAIT: begin
                if (w_ddone) begin
                    n_q = w_quo;
                    if (w_quo <= r_t) begin
                        n_sat = 1'b1;
                        n_t = ONE2;
                        n_state = ST_TWAIT;
                    end else begin
                        n_state = ST_TDIV;
                    end
                end
            end
            ST_TDIV: begin
                w_dstart = 1'b1;
                w_num = ONE2;
                w_den = r_q - r_t;
                n_state = ST_TWAIT;
            end
            ST_TWAIT: begin
                // Arrives here either from a forced tangent or a pending divide.
                if (w_ddone || r_q <= r_t) begin
                    if (w_ddone) n_t = w_quo;
                    n_i = r_i - 1'b1;
                    if (r_i == CNT_W'(1)) begin
                        if (!r_second) begin
                            n_ta = (w_ddone ? w_quo : r_t);
                            n_state = ST_DDIV;
                        end else begin
                            w_mstart = 1'b1;
                            n_state = ST_MUL;
                        end
                    end else begin
                        n_state = ST_QDIV;
                    end
                end
            end
            ST_DDIV: begin
                if (r_ta == '0) begin
                    n_sat = 1'b1;
                    n_dist = {OUT_W{1'b1}};
                    n_state = ST_DWAIT;
                end else begin
                    w_dstart = 1'b1;
                    w_num = 64'(r_h) << FRAC_BITS;
                    w_den = r_ta;
                    n_state = ST_DWAIT;
                end
            end
            ST_DWAIT: begin
                if (w_ddone || r_ta == '0) begin
                    if (w_ddone) begin
                        if (w_quo > OUT_MAX) begin
                            n_sat = 1'b1;
                            n_dist = {OUT_W{1'b1}};
                        end else begin
                            n_dist = w_quo[OUT_W-1:0];
                        end
                    end
                    if (r_beta != '0) begin
                        n_second = 1'b1;
                        n_t = '0;
                        n_i = r_n;
                        n_state = ST_QDIV;
                    end else begin
                        n_status = (r_sat || (w_ddone && w_quo > OUT_MAX))
                                   ? STATUS_SAT : STATUS_OK;
                        n_state = ST_DONE;
                    end
                end
            end
            ST_MUL: begin
                if (w_mdone) begin
                    if (w_sum[64:OUT_W] != '0 || w_msat) begin
                        n_objh = w_msat ? {OUT_W{1'b1}} + 48'd0 : {OUT_W{1'b1}};
                        n_sat = 1'b1;
                    end else begin
                        n_objh = w_sum[OUT_W-1:0];
                    end
                    if (w_msat) begin
                        // Saturated product plus height still exceeds 48 bits.
                        n_objh = {OUT_W{1'b1}};
                    end
                    n_status = (r_sat || w_msat || w_sum[64:OUT_W] != '0)
                               ? STATUS_SAT : STATUS_OK;
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else          r_state <= n_state;
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_go) begin
            r_alpha <= i_alpha;
            r_beta  <= i_beta;
            r_h     <= i_height;
            r_n     <= i_terms;
        end
        r_i      <= n_i;
        r_second <= n_second;
        r_t      <= n_t;
        r_q      <= n_q;
        r_dist   <= n_dist;
        r_objh   <= n_objh;
        r_sat    <= n_sat;
        r_status <= n_status;
        r_ta     <= n_ta;
    end

    assign o_busy          = (r_state != ST_IDLE);
    assign o_valid         = (r_state == ST_DONE);
    assign o_distance      = r_dist;
    assign o_object_height = r_objh;
    assign o_status        = r_status;
endmodule

// ===== sv/tangent_range_finder.sv =====
// Top level of the tangent range finder: configuration registers and sequencer.
// Depends on trf_pkg and trf_seq.
//
//  channel  | ports                                         | timing
//  ---------+-----------------------------------------------+------------------------
//  request  | i_start, o_busy, i_alpha_angle, i_beta_angle  | taken when start & !busy
//  result   | o_valid, o_distance, o_object_height, o_status| one-cycle strobe
//  config   | i_cfg_we, i_cfg_index, i_cfg_data             | write when we is high
//
// Every division runs on the single 64-bit restoring divider (start, then the
// quotient bit by bit, then done), and each continued fraction term takes two
// divisions unless its tangent is forced. A request runs from the accepting
// edge up to and including the result strobe; when beta is given, a second term
// loop and the height multiply follow the distance division. A range error goes
// straight to the strobe. Busy drops the cycle after the strobe. Reset returns
// the sequencer to idle and loads the default height and term count. The receiver cannot stall.
module tangent_range_finder #(
    parameter int FRAC_BITS = 16,
    parameter int MAX_TERMS = 13
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    output logic                      o_busy,
    input  logic [trf_pkg::ANG_W-1:0] i_alpha_angle,
    input  logic [trf_pkg::ANG_W-1:0] i_beta_angle,
    input  logic                      i_cfg_we,
    input  logic                      i_cfg_index,
    input  logic [trf_pkg::CFG_W-1:0] i_cfg_data,
    output logic                      o_valid,
    output logic [trf_pkg::OUT_W-1:0] o_distance,
    output logic [trf_pkg::OUT_W-1:0] o_object_height,
    output logic [1:0]                o_status
);
    import trf_pkg::*;

    logic [HGT_W-1:0] r_height;
    logic [CNT_W-1:0] r_terms;

    // Configuration writes are plain register loads; the register list has two
    // entries, so a one-bit index covers it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_height <= HGT_W'(98304);
            r_terms  <= CNT_W'(9);
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_HEIGHT) r_height <= i_cfg_data[HGT_W-1:0];
            if (i_cfg_index == CFG_TERMS)  r_terms  <= i_cfg_data[CNT_W-1:0];
        end
    end

    trf_seq #(.FRAC_BITS(FRAC_BITS), .MAX_TERMS(MAX_TERMS)) u_seq (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_go(i_start && !o_busy),
        .i_alpha(i_alpha_angle), .i_beta(i_beta_angle),
        .i_height(r_height), .i_terms(r_terms),
        .o_busy(o_busy), .o_valid(o_valid),
        .o_distance(o_distance), .o_object_height(o_object_height),
        .o_status(o_status)
    );
endmodule
